>>> rtl/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg: shared types and tables of the character set transcoder
// Item structs, charset and status codes, the CP1252 upper table and the
// code point encoder used by the front end.
// ----------------------------------------------------------------------------
package cht_pkg;

	localparam int CNT_BITS_DEF = 32;
	localparam int CNT_W        = 32;
	localparam int QDEPTH       = 4;
	localparam int QA_W         = $clog2(QDEPTH);
	localparam int QC_W         = $clog2(QDEPTH + 1);
	localparam int CP_W         = 21;

	typedef enum logic [1:0] {
		CS_UTF8    = 2'd0,
		CS_ASCII   = 2'd1,
		CS_LATIN1  = 2'd2,
		CS_WIN1252 = 2'd3
	} enc_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_INVALID    = 2'd1,
		ST_INCOMPLETE = 2'd2,
		ST_UNMAPPABLE = 2'd3
	} status_t;

	localparam logic       REG_SOURCE = 1'b0;
	localparam logic       REG_TARGET = 1'b1;
	localparam logic       KIND_DATA  = 1'b0;
	localparam logic       KIND_END   = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic             is_report;
		logic [7:0]       out_byte;
		logic [1:0]       status;
		logic [CNT_W-1:0] consumed_count;
		logic             last;
	} out_item_t;

	typedef struct packed {
		logic             is_report;
		logic [1:0]       nm1;
		logic [3:0][7:0]  bytes;
		logic [1:0]       status;
		logic [CNT_W-1:0] count;
	} q_entry_t;

	typedef struct packed {
		logic            ok;
		logic [1:0]      nm1;
		logic [3:0][7:0] bytes;
	} enc_res_t;

	localparam logic [15:0] WIN_TAB [32] = '{
		16'h20AC, 16'h0000, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
		16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
		16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
		16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178
	};

	function automatic enc_res_t encode_cp(input logic [CP_W-1:0] cp, input enc_t tgt);
		enc_res_t r;
		r = '0;
		unique case (tgt)
			CS_ASCII: begin
				r.ok       = (cp <= CP_W'(8'h7F));
				r.bytes[0] = cp[7:0];
			end
			CS_LATIN1: begin
				r.ok       = (cp <= CP_W'(8'hFF));
				r.bytes[0] = cp[7:0];
			end
			CS_WIN1252: begin
				if (cp <= CP_W'(8'h7F) || (cp >= CP_W'(8'hA0) && cp <= CP_W'(8'hFF))) begin
					r.ok       = 1'b1;
					r.bytes[0] = cp[7:0];
				end else begin
					for (int i = 0; i < 32; i++) begin
						if (WIN_TAB[i] != 16'h0000 && CP_W'(WIN_TAB[i]) == cp) begin
							r.ok       = 1'b1;
							r.bytes[0] = 8'h80 | 8'(i);
						end
					end
				end
			end
			CS_UTF8: begin
				r.ok = 1'b1;
				if (cp < CP_W'(8'h80)) begin
					r.bytes[0] = cp[7:0];
				end else if (cp < CP_W'(12'h800)) begin
					r.nm1      = 2'd1;
					r.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
					r.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
				end else if (cp < CP_W'(20'h10000)) begin
					r.nm1      = 2'd2;
					r.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
					r.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
					r.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
				end else begin
					r.nm1      = 2'd3;
					r.bytes[0] = 8'hF0 | {5'b00000, cp[20:18]};
					r.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
					r.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
					r.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
				end
			end
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/cht_front.sv
// ----------------------------------------------------------------------------
// cht_front: decode and classify stage
// Decodes each accepted byte in the source charset, gathers UTF-8 sequences,
// encodes finished code points and pushes characters and reports to the queue.
// ----------------------------------------------------------------------------
module cht_front #(
	parameter int COUNT_BITS = cht_pkg::CNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  cht_pkg::in_item_t item,
	input  cht_pkg::enc_t     src_enc,
	input  cht_pkg::enc_t     tgt_enc,
	output logic              push,
	output cht_pkg::q_entry_t push_entry
);
	import cht_pkg::*;

	logic [1:0]            exp_q, exp_d;
	logic [1:0]            gath_q, gath_d;
	logic [CP_W-1:0]       acc_q, acc_d;
	logic                  bad_q, bad_d;
	logic [COUNT_BITS-1:0] total_q, total_d;
	logic                  halted_q, halted_d;
	logic [1:0]            stop_q, stop_d;

	logic [7:0]      c;
	logic [CP_W-1:0] cp;
	logic [CP_W-1:0] acc_shift;
	logic [2:0]      len;
	logic            have_cp;
	logic            invalid;
	logic            bad_next;
	logic [1:0]      exp_dec;
	logic [15:0]     win_u;
	logic [63:0]     total_wide;
	enc_res_t        enc;

	assign c          = item.in_byte;
	assign acc_shift  = {acc_q[CP_W-7:0], c[5:0]};
	assign bad_next   = bad_q | (c[7:6] != 2'b10);
	assign exp_dec    = exp_q - 2'd1;
	assign win_u      = WIN_TAB[c[4:0]];
	assign total_wide = 64'(total_q);
	assign enc        = encode_cp(cp, tgt_enc);

	always_comb begin
		exp_d      = exp_q;
		gath_d     = gath_q;
		acc_d      = acc_q;
		bad_d      = bad_q;
		total_d    = total_q;
		halted_d   = halted_q;
		stop_d     = stop_q;
		push       = 1'b0;
		push_entry = '0;
		cp         = {13'd0, c};
		len        = 3'd1;
		have_cp    = 1'b0;
		invalid    = 1'b0;

		if (accept && item.kind == KIND_END) begin
			push                 = 1'b1;
			push_entry.is_report = 1'b1;
			push_entry.count     = total_wide[CNT_W-1:0];
			if (halted_q) begin
				push_entry.status = stop_q;
			end else if (exp_q != 2'd0) begin
				push_entry.status = ST_INCOMPLETE;
			end else begin
				push_entry.status = ST_OK;
			end
			exp_d    = '0;
			gath_d   = '0;
			acc_d    = '0;
			bad_d    = 1'b0;
			total_d  = '0;
			halted_d = 1'b0;
			stop_d   = ST_OK;
		end else if (accept && !halted_q) begin
			unique case (src_enc)
				CS_ASCII: begin
					invalid = c[7];
					have_cp = !c[7];
				end
				CS_LATIN1: begin
					have_cp = 1'b1;
				end
				CS_WIN1252: begin
					if (c[7:5] == 3'b100) begin
						cp      = CP_W'(win_u);
						invalid = (win_u == 16'h0000);
						have_cp = (win_u != 16'h0000);
					end else begin
						have_cp = 1'b1;
					end
				end
				CS_UTF8: begin
					if (exp_q == 2'd0) begin
						if (!c[7]) begin
							have_cp = 1'b1;
						end else if (c[7:5] == 3'b110) begin
							exp_d  = 2'd1;
							acc_d  = CP_W'(c[4:0]);
							gath_d = 2'd1;
							bad_d  = 1'b0;
						end else if (c[7:4] == 4'b1110) begin
							exp_d  = 2'd2;
							acc_d  = CP_W'(c[3:0]);
							gath_d = 2'd1;
							bad_d  = 1'b0;
						end else if (c[7:3] == 5'b11110) begin
							exp_d  = 2'd3;
							acc_d  = CP_W'(c[2:0]);
							gath_d = 2'd1;
							bad_d  = 1'b0;
						end else begin
							invalid = 1'b1;
						end
					end else begin
						exp_d = exp_dec;
						if (exp_dec != 2'd0) begin
							gath_d = gath_q + 2'd1;
							acc_d  = acc_shift;
							bad_d  = bad_next;
						end else begin
							gath_d  = '0;
							acc_d   = '0;
							bad_d   = 1'b0;
							cp      = acc_shift;
							len     = {1'b0, gath_q} + 3'd1;
							invalid = bad_next;
							have_cp = !bad_next;
						end
					end
				end
				default: invalid = 1'b1;
			endcase

			if (invalid || (have_cp && !enc.ok)) begin
				halted_d = 1'b1;
				stop_d   = invalid ? ST_INVALID : ST_UNMAPPABLE;
				exp_d    = '0;
				gath_d   = '0;
				acc_d    = '0;
				bad_d    = 1'b0;
			end else if (have_cp) begin
				push             = 1'b1;
				push_entry.nm1   = enc.nm1;
				push_entry.bytes = enc.bytes;
				total_d          = total_q + COUNT_BITS'(len);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q    <= '0;
			gath_q   <= '0;
			acc_q    <= '0;
			bad_q    <= 1'b0;
			total_q  <= '0;
			halted_q <= 1'b0;
			stop_q   <= ST_OK;
		end else begin
			exp_q    <= exp_d;
			gath_q   <= gath_d;
			acc_q    <= acc_d;
			bad_q    <= bad_d;
			total_q  <= total_d;
			halted_q <= halted_d;
			stop_q   <= stop_d;
		end
	end

endmodule

>>> rtl/cht_queue.sv
// ----------------------------------------------------------------------------
// cht_queue: character queue
// Short FIFO of decoded characters and reports between front and back end.
// ----------------------------------------------------------------------------
module cht_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cht_pkg::q_entry_t push_entry,
	input  logic              pop,
	output cht_pkg::q_entry_t head,
	output logic              empty,
	output logic              full
);
	import cht_pkg::*;

	q_entry_t          mem_q [QDEPTH];
	logic [QA_W-1:0]   wr_ptr_q;
	logic [QA_W-1:0]   rd_ptr_q;
	logic [QC_W-1:0]   count_q;

	assign head  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign full  = (count_q == QC_W'(QDEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QA_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QA_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QC_W'(push) - QC_W'(pop);
		end
	end

endmodule

>>> rtl/cht_back.sv
// ----------------------------------------------------------------------------
// cht_back: output serializer
// Emits the bytes of each queued character one per cycle while res_stall is low,
// or the report, through a registered output stage.
// ----------------------------------------------------------------------------
module cht_back (
	input  logic               clk,
	input  logic               arst_n,
	input  cht_pkg::q_entry_t  head,
	input  logic               empty,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_stall,
	output cht_pkg::out_item_t res_item
);
	import cht_pkg::*;

	logic       valid_q;
	out_item_t  item_q;
	logic [1:0] idx_q;
	logic       load;
	logic       take;
	logic       is_last;
	out_item_t  item_d;

	assign load      = !valid_q || !res_stall;
	assign take      = load && !empty;
	assign is_last   = head.is_report || (idx_q == head.nm1);
	assign pop       = take && is_last;
	assign res_valid = valid_q;
	assign res_item  = item_q;

	always_comb begin
		item_d                = '0;
		item_d.is_report      = head.is_report;
		item_d.last           = is_last;
		if (head.is_report) begin
			item_d.status         = head.status;
			item_d.consumed_count = head.count;
		end else begin
			item_d.out_byte = head.bytes[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_q <= item_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= !empty;
			if (take) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

endmodule

>>> rtl/charset_transcoder.sv
// Path: accepted byte -> front decode -> character queue -> output register.
// Throughput: one byte per cycle while byte_stall is low; output runs at one
// result per cycle while res_stall is low, so a character that encodes to n
// bytes takes n results; the four-entry queue absorbs it before the input stalls.
// Reset: clears the stream state, the queue and the output stage, and sets
// both charsets to UTF-8.
// ----------------------------------------------------------------------------
// charset_transcoder: byte stream charset converter
// Converts between UTF-8, ASCII, Latin-1 and CP1252 with status reports at
// each end-of-buffer marker.
// ----------------------------------------------------------------------------
module charset_transcoder #(
	parameter int COUNT_BITS = cht_pkg::CNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  cht_pkg::in_item_t  byte_item,
	output logic               res_valid,
	input  logic               res_stall,
	output cht_pkg::out_item_t res_item,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [1:0]         cfg_data
);
	import cht_pkg::*;

	enc_t     src_q;
	enc_t     tgt_q;
	logic     accept;
	logic     push;
	logic     pop;
	logic     empty;
	logic     full;
	q_entry_t push_entry;
	q_entry_t head;

	assign byte_stall = full;
	assign accept     = byte_valid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= CS_UTF8;
			tgt_q <= CS_UTF8;
		end else if (cfg_we) begin
			if (cfg_index == REG_SOURCE) begin
				src_q <= enc_t'(cfg_data);
			end
			if (cfg_index == REG_TARGET) begin
				tgt_q <= enc_t'(cfg_data);
			end
		end
	end

	cht_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (byte_item),
		.src_enc   (src_q),
		.tgt_enc   (tgt_q),
		.push      (push),
		.push_entry(push_entry)
	);

	cht_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	cht_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item (res_item)
	);

	a_report_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.is_report |-> res_item.last && res_item.out_byte == 8'h00)
		else $error("Report item without last flag or with a data byte.");

	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.is_report |->
			res_item.status == ST_OK && res_item.consumed_count == '0)
		else $error("Data item carries status or count.");

	a_char_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !res_item.last |=> res_valid && !res_item.is_report)
		else $error("Bytes of one character were not delivered back to back.");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |=> full)
		else $error("Character queue lost an entry while full.");

endmodule
